### rtl/assert_macros.svh
// Assertion helpers used by the level meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants of the moving-average LED level meter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int SAMPLE_W = 10;   // ADC word
    localparam int CFG_W    = 10;   // widest config register
    localparam int CFG_IDX_W = 2;
    localparam int BAR_W    = 4;
    localparam int MASK_W   = 8;
    localparam int DIV_W    = 10;   // divider denominator / remainder / quotient
    localparam int STEP_W   = 4;    // holds up to DIV_W steps

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASELINE = 2'd0,
        REG_NOISE    = 2'd1,
        REG_SENS     = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_LOAD,
        ST_AVG_RUN,
        ST_MAG,
        ST_LVL_LOAD,
        ST_LVL_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem0;   // numerator bits above the quotient, < den
        logic [DIV_W-1:0]  bits;   // remaining numerator bits, MSB aligned
        logic [DIV_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

### rtl/moving_average_led_level_meter.sv
// One word at a time: a new input word is accepted only in idle, after the
//   previous result has been loaded into the output register. The bit-serial
//   divider is shared by the average (10 steps) and the bar scaling
//   (clog2(LED_TOTAL+1) steps), which is skipped when the bar saturates.
// Reset (rst_n, async low) clears the sample line, total and fill count;
//   the config registers return to their reset values.
// ----------------------------------------------------------------------------
// moving_average_led_level_meter
// Moving average over a line of sample cells, baseline magnitude, noise gate
// and saturating LED bar scaling with a thermometer mask.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module moving_average_led_level_meter
    import mavg_pkg::*;
#(
    parameter int WINDOW_LEN = 24,
    parameter int LED_TOTAL  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [9:0] sample
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [3:0] bar_level, [11:4] led_mask,
                                            // [21:12] window_average
);

    // running total width: WINDOW_LEN full-scale samples
    localparam int TOT_W  = $clog2(WINDOW_LEN * 1023 + 1);
    // total as divider remainder and numerator bits
    localparam int TOTX_W = SAMPLE_W + DIV_W;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    // quotient bits of the bar scaling (quotient < LED_TOTAL when unsaturated)
    localparam int LQ     = $clog2(LED_TOTAL + 1);
    localparam int NL_W   = SAMPLE_W + LQ;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] baseline_reg, baseline_next;
    logic [CFG_W-1:0] noise_reg,    noise_next;
    logic [CFG_W-1:0] sens_reg,     sens_next;

    always_comb
    begin
        baseline_next = baseline_reg;
        noise_next    = noise_reg;
        sens_next     = sens_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BASELINE: baseline_next = cfg_data;
                REG_NOISE:    noise_next    = cfg_data;
                REG_SENS:     sens_next     = cfg_data;
                default:      ;   // unknown index: dropped
            endcase
        end
    end

    // ---------------- control ----------------
    state_t state_reg, state_next;
    logic   accept;
    logic   sat;
    logic   out_load;
    logic   avg_load;
    logic   mag_load;
    logic   lvl_load;
    logic   lvl_sat_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // ---------------- sample line ----------------
    logic [SAMPLE_W-1:0] sample_in;
    logic [SAMPLE_W-1:0] line [WINDOW_LEN+1];

    assign sample_in = s_tdata[SAMPLE_W-1:0];
    assign line[0]   = sample_in;

    // line[WINDOW_LEN] is the word that leaves the window on this accept
    for (genvar g = 0; g < WINDOW_LEN; g++)
    begin : g_cell
        mavg_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .din   (line[g]),
            .dout  (line[g+1])
        );
    end

    logic [TOT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] fill_reg,  fill_next;

    always_comb
    begin
        total_next = total_reg;
        fill_next  = fill_reg;
        if (accept)
        begin
            total_next = TOT_W'(total_reg - TOT_W'(line[WINDOW_LEN]) + TOT_W'(sample_in));
            if (fill_reg < CNT_W'(WINDOW_LEN))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // ---------------- datapath ----------------
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic [LQ-1:0]       level_reg;
    logic [SAMPLE_W-1:0] mag_raw;
    logic [SAMPLE_W-1:0] mag_gated;
    logic [CFG_W-1:0]    div_eff;
    logic [TOTX_W-1:0]   tot_x;
    logic [NL_W-1:0]     lvl_num;

    always_comb
    begin
        mag_raw   = (avg_reg >= baseline_reg) ? avg_reg - baseline_reg
                                              : baseline_reg - avg_reg;
        mag_gated = (mag_raw < noise_reg) ? '0 : mag_raw;
        div_eff   = (sens_reg == '0) ? CFG_W'(1) : sens_reg;
        sat       = (mag_reg >= div_eff);
        tot_x     = TOTX_W'(total_reg);
        lvl_num   = NL_W'(mag_reg) * NL_W'(LED_TOTAL);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_AVG_LOAD;
            ST_AVG_LOAD: state_next = ST_AVG_RUN;
            ST_AVG_RUN:  if (div_rsp.done) state_next = ST_MAG;
            ST_MAG:      state_next = ST_LVL_LOAD;
            ST_LVL_LOAD: state_next = sat ? ST_DONE : ST_LVL_RUN;
            ST_LVL_RUN:  if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready     = 1'b0;
        avg_load     = 1'b0;
        mag_load     = 1'b0;
        lvl_load     = 1'b0;
        lvl_sat_load = 1'b0;
        out_load     = 1'b0;
        div_req      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_AVG_LOAD:
            begin
                // total / fill; total >> 10 < fill since every word is < 1024
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(SAMPLE_W);
                div_req.rem0  = tot_x[SAMPLE_W +: DIV_W];
                div_req.bits  = DIV_W'(tot_x[SAMPLE_W-1:0]);
                div_req.den   = DIV_W'(fill_reg);
            end
            ST_AVG_RUN:
            begin
                avg_load = div_rsp.done;
            end
            ST_MAG:
            begin
                mag_load = 1'b1;
            end
            ST_LVL_LOAD:
            begin
                // mag * LED_TOTAL / div; only run when the quotient stays below LED_TOTAL
                lvl_sat_load  = sat;
                div_req.start = !sat;
                div_req.steps = STEP_W'(LQ);
                div_req.rem0  = lvl_num[NL_W-1:LQ];
                div_req.bits  = {lvl_num[LQ-1:0], (DIV_W-LQ)'(0)};
                div_req.den   = div_eff;
            end
            ST_LVL_RUN:
            begin
                lvl_load = div_rsp.done;
            end
            ST_DONE:
            begin
                out_load = !m_tvalid || m_tready;
            end
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    mavg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- output register ----------------
    logic                m_tvalid_reg, m_tvalid_next;
    logic [BAR_W-1:0]    bar_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [SAMPLE_W-1:0] wavg_reg;
    logic [MASK_W-1:0]   mask_comb;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            mask_comb[i] = (int'(level_reg) > i);
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            baseline_reg <= CFG_W'(0);
            noise_reg    <= CFG_W'(1);
            sens_reg     <= CFG_W'(3);
            total_reg    <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            baseline_reg <= baseline_next;
            noise_reg    <= noise_next;
            sens_reg     <= sens_next;
            total_reg    <= total_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_load)
        begin
            avg_reg <= div_rsp.quo;
        end
        if (mag_load)
        begin
            mag_reg <= mag_gated;
        end
        if (lvl_sat_load)
        begin
            level_reg <= LQ'(LED_TOTAL);
        end
        else if (lvl_load)
        begin
            level_reg <= div_rsp.quo[LQ-1:0];
        end
        if (out_load)
        begin
            bar_reg  <= BAR_W'(level_reg);
            mask_reg <= mask_comb;
            wavg_reg <= avg_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, wavg_reg, mask_reg, bar_reg};

    // ---------------- checks ----------------
    logic lvl_done;
    logic lvl_over;

    assign lvl_done = (state_reg == ST_LVL_RUN) && div_rsp.done;
    assign lvl_over = (div_rsp.quo >= DIV_W'(LED_TOTAL));

    `ASSERT_CLKRST(a_idle_div_quiet, clk, rst_n, s_tready |-> !div_rsp.busy, "div busy in idle")
    `ASSERT_CLK(a_fill_bound, clk, fill_reg <= CNT_W'(WINDOW_LEN), "fill count past window")
    `ASSERT_CLKRST(a_accept_starts, clk, rst_n, accept |=> state_reg == ST_AVG_LOAD, "no avg start")
    `ASSERT_CLKRST(a_lvl_unsat, clk, rst_n, lvl_done |-> !lvl_over, "unsaturated bar at LED count")

endmodule

### rtl/mavg_cell.sv
// ----------------------------------------------------------------------------
// mavg_cell
// One stage of the sample line: holds a sample, passes it on at each shift.
// ----------------------------------------------------------------------------
module mavg_cell
    import mavg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] dout
);

    logic [SAMPLE_W-1:0] data_reg;
    logic [SAMPLE_W-1:0] data_next;

    always_comb
    begin
        data_next = shift ? din : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

### rtl/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div
    import mavg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] cnt_reg,   cnt_next;
    logic [DIV_W-1:0]  rem_reg,   rem_next;
    logic [DIV_W-1:0]  bits_reg,  bits_next;
    logic [DIV_W-1:0]  quo_reg,   quo_next;
    logic [DIV_W-1:0]  den_reg,   den_next;
    logic [DIV_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, bits_reg[DIV_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            rem_next  = req.rem0;
            bits_next = req.bits;
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = req.steps;
            busy_next = (req.steps != '0);
            done_next = (req.steps == '0);
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            bits_next = {bits_reg[DIV_W-2:0], 1'b0};
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### bench/moving_average_led_level_meter_tb.sv
// ----------------------------------------------------------------------------
// moving_average_led_level_meter_tb
// Streams ADC sample words into the level meter and checks every bar/mask/
// average word against a scoreboard that tracks the sample line, the running
// total and the register settings. A directed opening covers the corner
// cases; random phases follow, each writing new register values and taking
// one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module moving_average_led_level_meter_tb
    import mavg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN = 24;
    localparam int LED_TOTAL  = 8;

    // index 3 has no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int SAMPLE_MAX   = 1023;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_WORDS  = 192;
    // longest quiet stretch of a correct run: the block latency plus the longest
    // plausible stall streak, taken many times over
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the averaging line and the registers.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [BAR_W-1:0]    bar_level;
        logic [MASK_W-1:0]   led_mask;
        logic [SAMPLE_W-1:0] window_average;
    } meter_word_t;

    class level_meter_scoreboard;
        int unsigned sample_line [WINDOW_LEN];
        int unsigned line_total;
        int unsigned next_cell;
        int unsigned held_count;
        int unsigned baseline;
        int unsigned noise_gate;
        int unsigned sens_div;
        meter_word_t pending_words [$];
        int unsigned errors;

        function new();
            foreach (sample_line[i]) sample_line[i] = 0;
            line_total = 0;
            next_cell  = 0;
            held_count = 0;
            baseline   = 0;
            noise_gate = 1;
            sens_div   = 3;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_BASELINE: baseline   = val;
                REG_NOISE:    noise_gate = val;
                REG_SENS:     sens_div   = val;
                default:      ;
            endcase
        endfunction

        // Accepted sample word: update the line and queue the expected output.
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            meter_word_t w;
            int unsigned avg;
            int unsigned mag;
            int unsigned den;
            int unsigned lvl;
            line_total = line_total - sample_line[next_cell] + smp;
            sample_line[next_cell] = smp;
            next_cell = (next_cell + 1 >= WINDOW_LEN) ? 0 : next_cell + 1;
            if (held_count < WINDOW_LEN)
                held_count++;
            avg = line_total / held_count;
            if (avg > SAMPLE_MAX)
                avg = SAMPLE_MAX;
            // magnitude either side of the baseline
            mag = (avg >= baseline) ? avg - baseline : baseline - avg;
            if (mag < noise_gate)
                mag = 0;
            den = (sens_div == 0) ? 1 : sens_div;
            lvl = (mag * LED_TOTAL) / den;
            if (lvl > LED_TOTAL)
                lvl = LED_TOTAL;
            w.bar_level      = BAR_W'(lvl);
            w.led_mask       = MASK_W'((64'd1 << lvl) - 64'd1);
            w.window_average = SAMPLE_W'(avg);
            pending_words.push_back(w);
        endfunction

        function void check_result(logic [23:0] data);
            meter_word_t w;
            if (pending_words.size() == 0)
            begin
                $error("output word with nothing expected: %h", data);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (data[3:0] !== w.bar_level)
                begin
                    $error("bar_level: expected %0d, actual %0d", w.bar_level, data[3:0]);
                    errors++;
                end
                if (data[11:4] !== w.led_mask)
                begin
                    $error("led_mask: expected %h, actual %h", w.led_mask, data[11:4]);
                    errors++;
                end
                if (data[21:12] !== w.window_average)
                begin
                    $error("window_average: expected %0d, actual %0d",
                           w.window_average, data[21:12]);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;    // [9:0] sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;         // [3:0] bar_level, [11:4] led_mask,
                                           // [21:12] window_average

    level_meter_scoreboard meter_sb;
    int unsigned           src_idle_pct = 0;   // chance per cycle the sender holds off
    int unsigned           sink_stall_pct = 0; // chance per cycle the receiver stalls
    int unsigned           quiet_cycles = 0;   // cycles with no handshake or register write

    moving_average_led_level_meter #(
        .WINDOW_LEN (WINDOW_LEN),
        .LED_TOTAL  (LED_TOTAL)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // ------------------------------------------------------------------------
    // Output side: check accepted words, drive the stall pattern, and keep
    // the quiet counter for the watchdog. All sampling uses pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                meter_sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog: a hung handshake ends the run
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("moving_average_led_level_meter: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks; all are entered and left on a rising edge.
    // ------------------------------------------------------------------------

    // One sample word. valid stays high across back-to-back words and is only
    // dropped when a gap is taken.
    task automatic send_word(input logic [SAMPLE_W-1:0] smp);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        meter_sb.note_sample(smp);
    endtask

    // Stop sending and let every expected word come out.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (meter_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        meter_sb.set_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    // Registers only change with the block idle.
    task automatic apply_config(input logic [CFG_W-1:0] base_v,
                                input logic [CFG_W-1:0] noise_v,
                                input logic [CFG_W-1:0] sens_v);
        drain();
        write_reg(REG_BASELINE, base_v);
        write_reg(REG_NOISE, noise_v);
        write_reg(REG_SENS, sens_v);
    endtask

    // Audio-like sample: often near the centre so the bar moves through its
    // range, some full-scale noise and some rail values.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int centre);
        int pick;
        int val;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            val = $urandom_range(0, SAMPLE_MAX);
        else if (pick < 8)
            val = centre + $urandom_range(0, 256) - 128;
        else
            val = pick[0] ? SAMPLE_MAX : 0;
        if (val < 0)
            val = 0;
        if (val > SAMPLE_MAX)
            val = SAMPLE_MAX;
        return SAMPLE_W'(val);
    endfunction

    function automatic logic [CFG_W-1:0] pick_divisor;
        case ($urandom_range(0, 5))
            0:       return '0;    // treated as one
            1:       return 10'd1;
            2:       return 10'd1023;
            3:       return CFG_W'($urandom_range(1, 1023));
            default: return CFG_W'($urandom_range(8, 200));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] base_v;
        logic [CFG_W-1:0] noise_v;
        logic [CFG_W-1:0] sens_v;
        int               centre;

        rst_n <= 1'b0;
        meter_sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset settings first: line still filling ---
        send_word(10'd0);
        send_word(10'd1023);      // average far above: bar saturates
        send_word(10'd3);
        send_word(10'd1023);

        // coarse sensitivity, no noise gate
        apply_config(10'd0, 10'd0, 10'd1023);
        send_word(10'd1023);
        send_word(10'd512);

        // write to an unmapped index must change nothing
        drain();
        write_reg(REG_UNMAPPED, 10'd1023);
        send_word(10'd512);

        // zero divisor behaves as one
        apply_config(10'd0, 10'd0, 10'd0);
        send_word(10'd1);
        send_word(10'd0);

        // average below the baseline: magnitude of the difference
        apply_config(10'd1023, 10'd0, 10'd1023);
        send_word(10'd0);
        send_word(10'd0);
        apply_config(10'd1023, 10'd0, 10'd1);
        send_word(10'd0);

        // maximal noise gate silences everything short of full scale
        apply_config(10'd0, 10'd1023, 10'd1);
        send_word(10'd1023);
        send_word(10'd0);

        // mid settings, rail samples
        apply_config(10'd300, 10'd5, 10'd100);
        send_word(10'd1023);
        send_word(10'd0);
        send_word(10'd300);

        // --- random phases ---
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 0)
            begin
                base_v  = 10'd0;
                noise_v = 10'd0;
                sens_v  = 10'd1;
            end
            else if (phase == 5)
            begin
                base_v  = 10'd1023;
                noise_v = 10'd1023;
                sens_v  = 10'd1023;
            end
            else
            begin
                base_v  = CFG_W'($urandom_range(0, 1023));
                noise_v = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 63))
                                               : CFG_W'($urandom_range(0, 1023));
                sens_v  = pick_divisor();
            end
            apply_config(base_v, noise_v, sens_v);
            // the odd stray write to the unmapped index
            if ($urandom_range(0, 1))
                write_reg(REG_UNMAPPED, CFG_W'($urandom));

            // idle pattern: none, sender only, receiver only, both
            case (phase % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 78;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 78;
                end
                default:
                begin
                    src_idle_pct   = 29;
                    sink_stall_pct = 29;
                end
            endcase

            centre = base_v;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // drift the signal centre now and then
                if ($urandom_range(0, 31) == 0)
                    centre = $urandom_range(0, SAMPLE_MAX);
                send_word(pick_sample(centre));
            end
        end

        // --- wind-down ---
        drain();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (meter_sb.errors == 0 && meter_sb.outstanding() == 0)
            $display("moving_average_led_level_meter: match");
        else
            $display("moving_average_led_level_meter: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/mavg_pkg.sv
rtl/mavg_cell.sv
rtl/mavg_div.sv
rtl/moving_average_led_level_meter.sv
bench/moving_average_led_level_meter_tb.sv
